>>> rtl/core/hst_pkg.sv
`timescale 1ns / 1ps

package hst_pkg;

    // Table size and queue depth defaults
    localparam int NUM_ENTRIES_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Register reset value
    localparam logic [15:0] LEAK_THRESHOLD_RESET = 16'd100;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ALLOC       = 2'd0,
        OP_FREE        = 2'd1,
        OP_SNAPSHOT    = 2'd2,
        OP_RESET_STATS = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    // Back-end sequencer states
    typedef enum logic {
        BACK_IDLE,
        BACK_EXEC
    } back_state_t;

    // Classified item passed from front to back (entry index travels beside it)
    typedef struct packed {
        op_t         op;
        status_t     status;
        logic        is_new;
        logic [31:0] byte_count;
    } q_item_t;

    // Per-entry statistics held in the back-end memory
    typedef struct packed {
        logic [31:0] live_count;
        logic [31:0] growth_streak;
        logic        alerted;
        logic [63:0] held_bytes;
        logic [63:0] baseline_bytes;
    } stats_t;

endpackage

>>> rtl/core/hst_front.sv
`timescale 1ns / 1ps

module hst_front #(
    parameter int NUM_ENTRIES = hst_pkg::NUM_ENTRIES_DEFAULT,
    parameter int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              q_full,
    input  logic [1:0]        op,
    input  logic [31:0]       client_id,
    input  logic [31:0]       byte_count,
    output logic              push,
    output hst_pkg::q_item_t  item,
    output logic [IDX_W-1:0]  item_idx
);
    import hst_pkg::*;

    logic [NUM_ENTRIES-1:0] valid_reg;
    logic [31:0]            key_reg [NUM_ENTRIES];

    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             claim;
    op_t              op_in;

    assign op_in = op_t'(op);
    assign push  = in_valid && !q_full;

    // Match the id against all registered keys, lowest index wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (key_reg[i] == client_id))
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // Find the lowest free entry
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Classify the beat and pick the entry it works on
    always_comb
    begin
        claim           = 1'b0;
        item.op         = op_in;
        item.byte_count = byte_count;
        item.is_new     = 1'b0;
        item.status     = STATUS_OK;
        item_idx        = hit_idx;
        if (!hit)
        begin
            if (op_in == OP_ALLOC)
            begin
                if (free_found)
                begin
                    claim       = 1'b1;
                    item.is_new = 1'b1;
                    item_idx    = free_idx;
                end
                else
                begin
                    item.status = STATUS_FULL;
                end
            end
            else
            begin
                item.status = STATUS_NOT_FOUND;
            end
        end
    end

    // Mark a claimed entry valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (push && claim)
        begin
            valid_reg[free_idx] <= 1'b1;
        end
    end

    // Record the key of a claimed entry
    always_ff @(posedge clk)
    begin
        if (push && claim)
        begin
            key_reg[free_idx] <= client_id;
        end
    end

endmodule

>>> rtl/core/hst_fifo.sv
`timescale 1ns / 1ps

module hst_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hst_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/hst_back.sv
`timescale 1ns / 1ps

module hst_back #(
    parameter int NUM_ENTRIES = hst_pkg::NUM_ENTRIES_DEFAULT,
    parameter int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [15:0]       leak_threshold,
    input  logic              q_empty,
    input  hst_pkg::q_item_t  q_item,
    input  logic [IDX_W-1:0]  q_idx,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [31:0]       live_count_out,
    output logic [31:0]       live_bytes_out,
    output logic              leak_alert
);
    import hst_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    stats_t           stats_mem [NUM_ENTRIES];
    stats_t           rd_data_reg;
    q_item_t          item_reg;
    logic [IDX_W-1:0] idx_reg;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] count_out_reg;
    logic [31:0] bytes_out_reg;
    logic        alert_reg;

    logic        out_free;
    logic        finish;
    logic        mem_we;
    stats_t      cur;
    stats_t      upd;
    logic [31:0] cnt_res;
    logic [31:0] bytes_res;
    logic        alert_res;

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BACK_EXEC;
                end
            end
            BACK_EXEC:
            begin
                if (out_free)
                begin
                    state_next = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        pop    = 1'b0;
        finish = 1'b0;
        unique case (state_reg)
            BACK_IDLE:
            begin
                pop = !q_empty;
            end
            BACK_EXEC:
            begin
                finish = out_free;
            end
            default:
            begin
                pop    = 1'b0;
                finish = 1'b0;
            end
        endcase
    end

    assign mem_we = finish && (item_reg.status == STATUS_OK);

    // Update the entry statistics for the held beat
    always_comb
    begin
        logic [64:0] sum;
        logic [31:0] thr;
        logic [31:0] streak_inc;

        cur = item_reg.is_new ? '0 : rd_data_reg;
        upd = cur;
        cnt_res   = '0;
        bytes_res = '0;
        alert_res = 1'b0;
        sum        = {1'b0, cur.held_bytes} + {33'd0, item_reg.byte_count};
        thr        = (leak_threshold == '0) ? 32'd1 : {16'd0, leak_threshold};
        streak_inc = (cur.growth_streak == '1) ? cur.growth_streak
                                               : cur.growth_streak + 32'd1;
        unique case (item_reg.op)
            OP_ALLOC:
            begin
                upd.live_count = (cur.live_count == '1) ? cur.live_count
                                                        : cur.live_count + 32'd1;
                upd.held_bytes = sum[64] ? '1 : sum[63:0];
                if (upd.held_bytes > cur.baseline_bytes)
                begin
                    upd.growth_streak = streak_inc;
                    if ((streak_inc >= thr) && !cur.alerted)
                    begin
                        upd.alerted = 1'b1;
                        alert_res   = 1'b1;
                    end
                end
                else
                begin
                    upd.growth_streak = '0;
                end
            end
            OP_FREE:
            begin
                upd.live_count = (cur.live_count == '0) ? cur.live_count
                                                        : cur.live_count - 32'd1;
                upd.held_bytes = (cur.held_bytes >= {32'd0, item_reg.byte_count})
                               ? cur.held_bytes - {32'd0, item_reg.byte_count} : '0;
                if (upd.held_bytes <= cur.baseline_bytes)
                begin
                    upd.growth_streak = '0;
                    upd.alerted       = 1'b0;
                end
            end
            OP_SNAPSHOT:
            begin
                upd.baseline_bytes = cur.held_bytes;
                upd.growth_streak  = '0;
                upd.alerted        = 1'b0;
                cnt_res            = cur.live_count;
                bytes_res          = cur.held_bytes[31:0];
            end
            OP_RESET_STATS:
            begin
                upd = '0;
            end
            default:
            begin
                upd = cur;
            end
        endcase
        if (item_reg.status != STATUS_OK)
        begin
            cnt_res   = '0;
            bytes_res = '0;
            alert_res = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Take the queued beat and read its entry
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg    <= q_item;
            idx_reg     <= q_idx;
            rd_data_reg <= stats_mem[q_idx];
        end
    end

    // Write back the updated entry
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stats_mem[idx_reg] <= upd;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg    <= item_reg.status;
            count_out_reg <= cnt_res;
            bytes_out_reg <= bytes_res;
            alert_reg     <= alert_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign live_count_out = count_out_reg;
    assign live_bytes_out = bytes_out_reg;
    assign leak_alert     = alert_reg;

endmodule

>>> rtl/core/heap_slot_tracker_leak_detect_core.sv
`timescale 1ns / 1ps

// Heap client tracker with a leak heuristic. Each beat names an operation
// (alloc, free, snapshot, reset statistics) on a client id and returns one
// result beat with a status, the snapshot counters and a one-time leak alert.
// The front end matches the id against all table keys combinationally, claims a
// free entry for a new client and queues the beat in a two-entry queue; it
// takes a new beat every cycle while the queue has room. The back end first
// reads the entry's statistics from the memory, then updates them, writes them
// back and loads the result register, holding while the result is stalled. It
// takes no new beat until that read-modify-write is done. There is no clearing
// pass after reset. The leak_threshold register is written over the cfg port,
// which is always ready; write it only while the block is idle.
module heap_slot_tracker_leak_detect_core #(
    parameter int NUM_ENTRIES = hst_pkg::NUM_ENTRIES_DEFAULT,
    parameter int QUEUE_DEPTH = hst_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [31:0] client_id,
    input  logic [31:0] byte_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] live_count_out,
    output logic [31:0] live_bytes_out,
    output logic        leak_alert
);
    import hst_pkg::*;

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int Q_W   = $bits(q_item_t) + IDX_W;

    logic [15:0]      threshold_reg;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    q_item_t          front_item;
    logic [IDX_W-1:0] front_idx;
    logic [Q_W-1:0]   q_head;
    q_item_t          back_item;
    logic [IDX_W-1:0] back_idx;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    // Hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= LEAK_THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_data;
        end
    end

    hst_front #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .q_full     (q_full),
        .op         (op),
        .client_id  (client_id),
        .byte_count (byte_count),
        .push       (push),
        .item       (front_item),
        .item_idx   (front_idx)
    );

    hst_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({front_item, front_idx}),
        .pop       (pop),
        .pop_data  (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign back_item = q_item_t'(q_head[Q_W-1:IDX_W]);
    assign back_idx  = q_head[IDX_W-1:0];

    hst_back #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .leak_threshold (threshold_reg),
        .q_empty        (q_empty),
        .q_item         (back_item),
        .q_idx          (back_idx),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .live_count_out (live_count_out),
        .live_bytes_out (live_bytes_out),
        .leak_alert     (leak_alert)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import hst_pkg::*;

    localparam int SLOTS       = NUM_ENTRIES_DEFAULT;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 150;
    localparam int PHASES      = 5;

    typedef struct {
        status_t     status;
        logic [31:0] count;
        logic [31:0] bytes;
        logic        alert;
    } tracker_answer_t;

    // Client table mirror plus the queue of answers still owed by the block
    class heap_tracker_board;
        logic [15:0] threshold;
        bit          used[SLOTS];
        logic [31:0] key[SLOTS];
        logic [31:0] live_count[SLOTS];
        logic [31:0] streak[SLOTS];
        bit          alerted[SLOTS];
        logic [63:0] held_bytes[SLOTS];
        logic [63:0] baseline[SLOTS];
        tracker_answer_t answers_due[$];
        int          errors;

        function new();
            threshold = LEAK_THRESHOLD_RESET;
            errors = 0;
            for (int i = 0; i < SLOTS; i++)
                used[i] = 1'b0;
        endfunction

        function void set_threshold(logic [15:0] value);
            threshold = value;
        endfunction

        function void clear_slot(int slot);
            live_count[slot] = '0;
            streak[slot]     = '0;
            alerted[slot]    = 1'b0;
            held_bytes[slot] = '0;
            baseline[slot]   = '0;
        endfunction

        // Apply one accepted beat to the table and queue the answer it earns
        function void record_request(op_t kind, logic [31:0] id, logic [31:0] amount);
            int slot;
            logic [31:0] thr;
            logic [63:0] wide;
            tracker_answer_t ans;
            ans.status = STATUS_OK;
            ans.count  = '0;
            ans.bytes  = '0;
            ans.alert  = 1'b0;
            wide = {32'd0, amount};
            slot = -1;
            // a registered client with a matching id wins
            for (int i = 0; i < SLOTS; i++)
                if (slot < 0 && used[i] && key[i] == id)
                    slot = i;
            if (kind == OP_ALLOC)
            begin
                // new client takes the lowest free entry
                if (slot < 0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot < 0 && !used[i])
                            slot = i;
                    if (slot >= 0)
                    begin
                        used[slot] = 1'b1;
                        key[slot]  = id;
                        clear_slot(slot);
                    end
                end
                if (slot < 0)
                    ans.status = STATUS_FULL;
                else
                begin
                    thr = (threshold == 16'd0) ? 32'd1 : {16'd0, threshold};
                    if (live_count[slot] != 32'hFFFF_FFFF)
                        live_count[slot] = live_count[slot] + 32'd1;
                    if (held_bytes[slot] > 64'hFFFF_FFFF_FFFF_FFFF - wide)
                        held_bytes[slot] = 64'hFFFF_FFFF_FFFF_FFFF;
                    else
                        held_bytes[slot] = held_bytes[slot] + wide;
                    // growth streak and one-time alert
                    if (held_bytes[slot] > baseline[slot])
                    begin
                        if (streak[slot] != 32'hFFFF_FFFF)
                            streak[slot] = streak[slot] + 32'd1;
                        if (streak[slot] >= thr && !alerted[slot])
                        begin
                            alerted[slot] = 1'b1;
                            ans.alert = 1'b1;
                        end
                    end
                    else
                        streak[slot] = '0;
                end
            end
            else if (slot < 0)
                ans.status = STATUS_NOT_FOUND;
            else if (kind == OP_FREE)
            begin
                if (live_count[slot] != 32'd0)
                    live_count[slot] = live_count[slot] - 32'd1;
                if (held_bytes[slot] >= wide)
                    held_bytes[slot] = held_bytes[slot] - wide;
                else
                    held_bytes[slot] = '0;
                // re-arm once back at or under the baseline
                if (held_bytes[slot] <= baseline[slot])
                begin
                    streak[slot]  = '0;
                    alerted[slot] = 1'b0;
                end
            end
            else if (kind == OP_SNAPSHOT)
            begin
                baseline[slot] = held_bytes[slot];
                streak[slot]   = '0;
                alerted[slot]  = 1'b0;
                ans.count = live_count[slot];
                ans.bytes = held_bytes[slot][31:0];
            end
            else
                clear_slot(slot);
            answers_due.push_back(ans);
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR at %0t ns: %s", $time, msg);
        endtask

        // Compare one result beat with the oldest owed answer
        task check_answer(logic [1:0] st, logic [31:0] cnt, logic [31:0] byt, logic alrt);
            tracker_answer_t want;
            if (answers_due.size() == 0)
            begin
                report("result beat with no request outstanding");
                return;
            end
            want = answers_due.pop_front();
            if (st !== want.status)
                report($sformatf("status got %0d want %0d", st, want.status));
            if (cnt !== want.count)
                report($sformatf("live_count_out got %0h want %0h", cnt, want.count));
            if (byt !== want.bytes)
                report($sformatf("live_bytes_out got %0h want %0h", byt, want.bytes));
            if (alrt !== want.alert)
                report($sformatf("leak_alert got %0b want %0b", alrt, want.alert));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = '0;
    logic [31:0] client_id = '0;
    logic [31:0] byte_count = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] live_count_out;
    logic [31:0] live_bytes_out;
    logic        leak_alert;

    heap_tracker_board board;
    logic [31:0]       pool[SLOTS];
    bit                send_idle = 1'b1;
    bit                recv_idle = 1'b1;
    int                hold_len = 0;
    int                quiet_cycles = 0;

    heap_slot_tracker_leak_detect_core #(
        .NUM_ENTRIES(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .client_id(client_id),
        .byte_count(byte_count),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .live_count_out(live_count_out),
        .live_bytes_out(live_bytes_out),
        .leak_alert(leak_alert)
    );

    always #10 clk = ~clk;

    // Observe the input, result and cfg handshakes and watch for a hung block
    always @(posedge clk)
    begin
        bit moved;
        moved = 1'b0;
        if (in_valid === 1'b1 && in_stall === 1'b0)
        begin
            board.record_request(op_t'(op), client_id, byte_count);
            moved = 1'b1;
        end
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            board.check_answer(status, live_count_out, live_bytes_out, leak_alert);
            moved = 1'b1;
        end
        if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
            moved = 1'b1;
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("heap_slot_tracker_leak_detect_core: mismatch");
            $finish;
        end
    end

    // Result side: stall for a random wait per beat while recv_idle is set, or for hold_len on request
    initial
    begin
        int wait_n;
        @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                wait_n = hold_len;
                hold_len = 0;
            end
            else
                wait_n = recv_idle ? $urandom_range(0, 3) : 0;
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
        end
    end

    // Offer one beat, after a random gap while send_idle is set, and hold it until taken
    task send_beat(op_t kind, logic [31:0] id, logic [31:0] amount);
        int gap;
        gap = send_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= kind;
        client_id  <= id;
        byte_count <= amount;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    // Drop valid and wait until every owed answer is back
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.answers_due.size() != 0)
            @(posedge clk);
    endtask

    task write_threshold(logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        board.set_threshold(value);
        cfg_valid <= 1'b0;
    endtask

    // Mostly a few hot clients, some spread over the table, a few strangers
    task send_random();
        int pick;
        int kind_pick;
        int size_pick;
        logic [31:0] id;
        logic [31:0] amount;
        op_t kind;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            id = $urandom;
        else if (pick < 66)
            id = pool[$urandom_range(0, 3)];
        else
            id = pool[$urandom_range(0, SLOTS - 1)];
        kind_pick = $urandom_range(0, 99);
        if (kind_pick < 45)
            kind = OP_ALLOC;
        else if (kind_pick < 70)
            kind = OP_FREE;
        else if (kind_pick < 88)
            kind = OP_SNAPSHOT;
        else
            kind = OP_RESET_STATS;
        size_pick = $urandom_range(0, 15);
        case (size_pick)
            0:       amount = 32'd0;
            1:       amount = 32'hFFFF_FFFF;
            2:       amount = $urandom;
            default: amount = $urandom_range(1, 64);
        endcase
        send_beat(kind, id, amount);
    endtask

    initial
    begin
        logic [15:0] thresholds[PHASES];
        board = new();
        thresholds[0] = 16'd1;
        thresholds[1] = 16'd3;
        thresholds[2] = 16'd0;
        thresholds[3] = 16'hFFFF;
        thresholds[4] = 16'($urandom_range(2, 8));
        pool[0] = 32'd0;
        pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < SLOTS; i++)
            pool[i] = $urandom;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unknown ids, max-size allocs and saturating frees at the reset threshold
        send_beat(OP_FREE, 32'd0, 32'd7);
        send_beat(OP_SNAPSHOT, 32'hFFFF_FFFF, 32'd0);
        send_beat(OP_RESET_STATS, 32'h1234_5678, 32'hFFFF_FFFF);
        send_beat(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send_beat(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send_beat(OP_SNAPSHOT, 32'd0, 32'd0);
        send_beat(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_beat(OP_FREE, 32'hFFFF_FFFF, 32'd5);
        send_beat(OP_FREE, 32'hFFFF_FFFF, 32'd0);
        send_beat(OP_SNAPSHOT, 32'hFFFF_FFFF, 32'd0);
        send_beat(OP_RESET_STATS, 32'd0, 32'd0);
        send_beat(OP_SNAPSHOT, 32'd0, 32'd0);
        drain();

        // alert fires once, re-arms after a free back to the baseline
        write_threshold(16'd1);
        send_beat(OP_ALLOC, 32'd0, 32'd1);
        send_beat(OP_ALLOC, 32'd0, 32'd1);
        send_beat(OP_FREE, 32'd0, 32'd2);
        send_beat(OP_ALLOC, 32'd0, 32'd3);
        send_beat(OP_SNAPSHOT, 32'd0, 32'd0);

        // random phases, one per threshold setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            send_idle = (ph != 1);
            recv_idle = (ph != 2);
            write_threshold(thresholds[ph]);
            if (ph == 1)
                hold_len = 60;
            repeat (PHASE_ITEMS) send_random();
        end

        drain();
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("heap_slot_tracker_leak_detect_core: match");
        else
            $display("heap_slot_tracker_leak_detect_core: mismatch");
        $finish;
    end

endmodule

>>> heap_slot_tracker_leak_detect_core.f
rtl/core/hst_pkg.sv
rtl/core/hst_front.sv
rtl/core/hst_fifo.sv
rtl/core/hst_back.sv
rtl/core/heap_slot_tracker_leak_detect_core.sv
bench/testbench.sv
